>>> sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while rst is high
`define CHK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen
`define CHK_NEVER(lbl, expr, msg) \
  `CHK_PROP(lbl, !(expr), msg)

`endif

>>> sv/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

  // default grid storage
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // field widths
  localparam int OP_W   = 2;
  localparam int POS_W  = 6;
  localparam int SIZE_W = 7;
  localparam int CNT_W  = 4;

  // op codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // register indexes
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // life rule
  localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [CNT_W-1:0] SURVIVE_LOW = 4'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WR_READ,
    ST_WR_MOD,
    ST_RD_UP,
    ST_RD_MID,
    ST_RD_DN,
    ST_RD_SHIFT,
    ST_STEP,
    ST_RESP
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_ABOVE,
    RD_CENTER,
    RD_BELOW,
    RD_SCAN
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CELL,
    WR_SCAN,
    WR_CLEAR
  } wr_sel_t;

  typedef struct packed {
    logic    latch;
    logic    scan_clr;
    logic    scan_inc;
    logic    win_clr;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    load_res;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_grid;
    logic            step_last;
    logic            clear_last;
  } dp_stat_t;

endpackage

>>> sv/life_grid_generation_step_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   direction  handshake            word
// item      in         start, busy          op, row, col, alive_in
// result    out        done (one cycle)     alive_out, neighbour_count, out_of_range
// config    in         cfg_valid, cfg_ready cfg_index, cfg_data
//
// from accept to the done strobe: out of range or unused op go from decode to the
// result, write reads the row and writes it back, read does three single-port row
// reads into the window, a step moves one grid row per cycle through the single port
// after reset a clearing pass empties the grid, busy is high
// a new item may be accepted in the cycle that done is shown
// the receiver cannot stall, each result word is shown for exactly one cycle

module life_grid_generation_step_top import lgs_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic              clk,
  input  logic              rst,
  // item word
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   op,
  input  logic [POS_W-1:0]  row,
  input  logic [POS_W-1:0]  col,
  input  logic              alive_in,
  // result word
  output logic              done,
  output logic              alive_out,
  output logic [CNT_W-1:0]  neighbour_count,
  output logic              out_of_range,
  // size registers
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // size writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: clearing pass, decode, row reads, scan, result
  lgs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // grid memory, row window, per-column neighbour lanes, result registers
  lgs_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .op              (op),
    .row             (row),
    .col             (col),
    .alive_in        (alive_in),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .alive_out       (alive_out),
    .neighbour_count (neighbour_count),
    .out_of_range    (out_of_range)
  );

  // an accepted item keeps the block busy in the next cycle
  `CHK_PROP(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
  // each item passes through decode and result states, so result strobes never touch
  `CHK_PROP(a_done_pulse, done |=> !done, "result strobe held for two cycles")
  // an out of range result carries nothing else
  `CHK_NEVER(a_oor_clean, done && out_of_range && (alive_out || neighbour_count != '0),
             "out of range result has payload")
  // at most eight neighbours
  `CHK_NEVER(a_cnt_max, done && (neighbour_count > CNT_W'(8)), "neighbour count above eight")

endmodule

>>> sv/lgs_ctrl.sv
`timescale 1ns / 1ps

module lgs_ctrl import lgs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (stat.op == OP_STEP)               state_next = ST_STEP;
        else if (stat.op == OP_WRITE && stat.in_grid) state_next = ST_WR_READ;
        else if (stat.op == OP_READ && stat.in_grid)  state_next = ST_RD_UP;
        else                                           state_next = ST_RESP;
      end
      ST_WR_READ:  state_next = ST_WR_MOD;
      ST_WR_MOD:   state_next = ST_RESP;
      ST_RD_UP:    state_next = ST_RD_MID;
      ST_RD_MID:   state_next = ST_RD_DN;
      ST_RD_DN:    state_next = ST_RD_SHIFT;
      ST_RD_SHIFT: state_next = ST_RESP;
      ST_STEP: begin
        if (stat.step_last) state_next = ST_RESP;
      end
      ST_RESP:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{latch: 1'b0, scan_clr: 1'b0, scan_inc: 1'b0, win_clr: 1'b0,
            rd_sel: RD_NONE, wr_sel: WR_NONE, load_res: 1'b0};
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.wr_sel   = WR_CLEAR;
        cmd.scan_inc = 1'b1;
      end
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_DECODE: begin
        cmd.scan_clr = 1'b1;
        cmd.win_clr  = 1'b1;
      end
      ST_WR_READ:  cmd.rd_sel = RD_CENTER;
      ST_WR_MOD:   cmd.wr_sel = WR_CELL;
      ST_RD_UP:    cmd.rd_sel = RD_ABOVE;
      ST_RD_MID:   cmd.rd_sel = RD_CENTER;
      ST_RD_DN:    cmd.rd_sel = RD_BELOW;
      ST_RD_SHIFT: cmd.rd_sel = RD_NONE;
      ST_STEP: begin
        cmd.rd_sel   = RD_SCAN;
        cmd.wr_sel   = WR_SCAN;
        cmd.scan_inc = 1'b1;
      end
      ST_RESP:     cmd.load_res = 1'b1;
      default:     busy = 1'b1;
    endcase
  end

endmodule

>>> sv/lgs_dp.sv
`timescale 1ns / 1ps

module lgs_dp import lgs_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [OP_W-1:0]   op,
  input  logic [POS_W-1:0]  row,
  input  logic [POS_W-1:0]  col,
  input  logic              alive_in,
  input  logic              cfg_wr,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  output logic              done,
  output logic              alive_out,
  output logic [CNT_W-1:0]  neighbour_count,
  output logic              out_of_range
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int SCW = $clog2(MAX_ROWS + 3);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int RNW = (SCW > SIZE_W) ? SCW : SIZE_W;
  localparam int CNW = (CCW > SIZE_W) ? CCW : SIZE_W;

  // size registers
  logic [SIZE_W-1:0] grid_rows, grid_cols;
  logic [RNW-1:0]    nr;
  logic [CNW-1:0]    nc;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= SIZE_RESET;
      grid_cols <= SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_GRID_ROWS: grid_rows <= cfg_data;
        REG_GRID_COLS: grid_cols <= cfg_data;
      endcase
    end
  end

  // zero acts as one, too large acts as the storage size
  always_comb begin
    priority if (grid_rows == '0)                 nr = RNW'(1);
    else if (RNW'(grid_rows) > RNW'(MAX_ROWS))    nr = RNW'(MAX_ROWS);
    else                                          nr = RNW'(grid_rows);
    priority if (grid_cols == '0)                 nc = CNW'(1);
    else if (CNW'(grid_cols) > CNW'(MAX_COLS))    nc = CNW'(MAX_COLS);
    else                                          nc = CNW'(grid_cols);
  end

  // latched item
  logic [OP_W-1:0]  op_q;
  logic [POS_W-1:0] row_q, col_q;
  logic             alive_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= op;
      row_q   <= row;
      col_q   <= col;
      alive_q <= alive_in;
    end
  end

  logic in_grid;
  assign in_grid = (RNW'(row_q) < nr) && (CNW'(col_q) < nc);

  // row counter for the clearing pass and the generation scan
  logic [SCW-1:0] scan;
  logic [RNW-1:0] scan_w, wr_row_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (cmd.scan_clr) begin
      scan <= '0;
    end else if (cmd.scan_inc) begin
      scan <= scan + SCW'(1);
    end
  end

  assign scan_w   = RNW'(scan);
  assign wr_row_w = scan_w - RNW'(3);

  assign stat.op         = op_q;
  assign stat.in_grid    = in_grid;
  assign stat.step_last  = (scan_w == nr + RNW'(2));
  assign stat.clear_last = (scan == SCW'(MAX_ROWS - 1));

  // read side
  logic [RW-1:0] rd_addr;
  logic          rd_en, rd_dead_c;

  always_comb begin
    rd_en     = 1'b1;
    rd_addr   = RW'(row_q);
    rd_dead_c = 1'b0;
    unique case (cmd.rd_sel)
      RD_NONE: rd_en = 1'b0;
      RD_ABOVE: begin
        rd_addr   = RW'(row_q - POS_W'(1));
        rd_dead_c = (row_q == '0);
      end
      RD_CENTER: rd_addr = RW'(row_q);
      RD_BELOW: begin
        rd_addr   = RW'(row_q + POS_W'(1));
        rd_dead_c = ((RNW'(row_q) + RNW'(1)) >= nr);
      end
      RD_SCAN: begin
        rd_addr   = RW'(scan);
        rd_dead_c = (scan_w >= nr);
      end
      default: rd_en = 1'b0;
    endcase
  end

  logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data;
  logic                rd_v, rd_dead;

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= grid_mem[rd_addr];
    rd_dead <= rd_dead_c;
  end

  always_ff @(posedge clk) begin
    if (rst) rd_v <= 1'b0;
    else     rd_v <= rd_en;
  end

  // three row window
  logic [MAX_COLS-1:0] win_prev, win_cur, win_nxt;

  always_ff @(posedge clk) begin
    if (cmd.win_clr) begin
      win_prev <= '0;
      win_cur  <= '0;
      win_nxt  <= '0;
    end else if (rd_v) begin
      win_prev <= win_cur;
      win_cur  <= win_nxt;
      win_nxt  <= rd_dead ? '0 : rd_data;
    end
  end

  // one lane per column
  logic [MAX_COLS-1:0] col_mask, new_row;
  logic [MAX_COLS+1:0] pad_p, pad_c, pad_n;
  logic [CNT_W-1:0]    lane_cnt [MAX_COLS];

  assign pad_p = {1'b0, win_prev & col_mask, 1'b0};
  assign pad_c = {1'b0, win_cur  & col_mask, 1'b0};
  assign pad_n = {1'b0, win_nxt  & col_mask, 1'b0};

  for (genvar x = 0; x < MAX_COLS; x++) begin : g_lane
    assign col_mask[x] = (CNW'(x) < nc);
    assign lane_cnt[x] = CNT_W'(pad_p[x]) + CNT_W'(pad_p[x+1]) + CNT_W'(pad_p[x+2])
                       + CNT_W'(pad_c[x])                      + CNT_W'(pad_c[x+2])
                       + CNT_W'(pad_n[x]) + CNT_W'(pad_n[x+1]) + CNT_W'(pad_n[x+2]);
    // columns beyond the size keep their value
    assign new_row[x] = col_mask[x]
                      ? ((lane_cnt[x] == BIRTH_COUNT)
                         | (win_cur[x] & (lane_cnt[x] == SURVIVE_LOW)))
                      : win_cur[x];
  end

  // write side
  logic                wr_en;
  logic [RW-1:0]       wr_addr;
  logic [MAX_COLS-1:0] wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = RW'(row_q);
    wr_data = rd_data;
    unique case (cmd.wr_sel)
      WR_NONE: wr_en = 1'b0;
      WR_CELL: begin
        wr_en = 1'b1;
        wr_data[CIW'(col_q)] = alive_q;
      end
      WR_SCAN: begin
        wr_en   = (scan_w >= RNW'(3)) && (wr_row_w < nr);
        wr_addr = RW'(wr_row_w);
        wr_data = new_row;
      end
      WR_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = RW'(scan);
        wr_data = '0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.load_res;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      alive_out       <= 1'b0;
      neighbour_count <= '0;
      out_of_range    <= 1'b0;
      if (op_q == OP_WRITE || op_q == OP_READ) begin
        if (!in_grid) begin
          out_of_range <= 1'b1;
        end else if (op_q == OP_WRITE) begin
          alive_out <= alive_q;
        end else begin
          alive_out       <= win_cur[CIW'(col_q)];
          neighbour_count <= lane_cnt[CIW'(col_q)];
        end
      end
    end
  end

endmodule

>>> verif/life_grid_checker.sv
`timescale 1ns / 1ps

module life_grid_checker import lgs_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [OP_W-1:0]   op,
  input  logic [POS_W-1:0]  row,
  input  logic [POS_W-1:0]  col,
  input  logic              alive_in,
  input  logic              done,
  input  logic              alive_out,
  input  logic [CNT_W-1:0]  neighbour_count,
  input  logic              out_of_range,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  output int                fail_count,
  output int                words_pending
);

  typedef struct packed {
    logic             alive;
    logic [CNT_W-1:0] count;
    logic             oor;
  } life_result_t;

  bit                life_grid [MAX_ROWS][MAX_COLS];
  bit                life_next [MAX_ROWS][MAX_COLS];
  logic [SIZE_W-1:0] rows_reg = SIZE_RESET;
  logic [SIZE_W-1:0] cols_reg = SIZE_RESET;
  life_result_t      expected_q [$];
  int                mismatches = 0;

  // zero acts as one, anything past the storage acts as the storage size
  function automatic int usable_size(logic [SIZE_W-1:0] raw, int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return int'(raw);
  endfunction

  // cells beyond the used size count as dead
  function automatic logic [CNT_W-1:0] live_around(int r, int c, int nr, int nc);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if ((dr != 0 || dc != 0) && r + dr >= 0 && c + dc >= 0 && r + dr < nr && c + dc < nc)
          n += life_grid[r + dr][c + dc];
    return n;
  endfunction

  function automatic life_result_t predict_word(logic [OP_W-1:0] o, logic [POS_W-1:0] r,
                                                logic [POS_W-1:0] c, logic a);
    life_result_t     res;
    int               nr;
    int               nc;
    bit               inside_grid;
    logic [CNT_W-1:0] n;
    res = '0;
    nr = usable_size(rows_reg, MAX_ROWS);
    nc = usable_size(cols_reg, MAX_COLS);
    inside_grid = (r < nr) && (c < nc);
    case (o)
      OP_WRITE, OP_READ: begin
        if (!inside_grid) begin
          res.oor = 1'b1;
        end else if (o == OP_WRITE) begin
          life_grid[r][c] = a;
          res.alive = a;
        end else begin
          res.alive = life_grid[r][c];
          res.count = live_around(r, c, nr, nc);
        end
      end
      OP_STEP: begin
        // whole new generation from the old snapshot, then copy back
        for (int y = 0; y < nr; y++)
          for (int x = 0; x < nc; x++) begin
            n = live_around(y, x, nr, nc);
            if (life_grid[y][x])
              life_next[y][x] = (n >= SURVIVE_LOW) && (n <= BIRTH_COUNT);
            else
              life_next[y][x] = (n == BIRTH_COUNT);
          end
        for (int y = 0; y < nr; y++)
          for (int x = 0; x < nc; x++)
            life_grid[y][x] = life_next[y][x];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    life_result_t want;
    if (rst) begin
      foreach (life_grid[y, x]) life_grid[y][x] = 1'b0;
      rows_reg = SIZE_RESET;
      cols_reg = SIZE_RESET;
      expected_q.delete();
    end else begin
      // result word of an earlier item, checked before a new item is taken
      if (done) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing expected: alive %0b count %0d range %0b",
                     $realtime, alive_out, neighbour_count, out_of_range);
        end else begin
          want = expected_q.pop_front();
          if (want.alive !== alive_out || want.count !== neighbour_count ||
              want.oor !== out_of_range) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch alive exp %0b got %0b, count exp %0d got %0d, range exp %0b got %0b",
                       $realtime, want.alive, alive_out, want.count, neighbour_count,
                       want.oor, out_of_range);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_ROWS) rows_reg = cfg_data;
        else if (cfg_index == REG_GRID_COLS) cols_reg = cfg_data;
      end
      if (start && !busy) expected_q.push_back(predict_word(op, row, col, alive_in));
    end
    fail_count    <= mismatches;
    words_pending <= expected_q.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lgs_pkg::*;

  // op code the block leaves unused, answered with an all-zero word
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_GAP         = 17;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int RANDOM_PHASES   = 8;
  // longest quiet stretch of a good run is a clearing pass, a 64-row step,
  // a full sender gap and the final drain; this is many times that
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 80;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic [OP_W-1:0]   op        = OP_WRITE;
  logic [POS_W-1:0]  row       = '0;
  logic [POS_W-1:0]  col       = '0;
  logic              alive_in  = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_index = REG_GRID_ROWS;
  logic [SIZE_W-1:0] cfg_data  = SIZE_RESET;
  logic              busy;
  logic              done;
  logic              alive_out;
  logic [CNT_W-1:0]  neighbour_count;
  logic              out_of_range;
  logic              cfg_ready;
  int                fail_count;
  int                words_pending;
  int                stall_cycles = 0;

  // size as the block will use it, for shaping the stimulus
  int                usable_rows = DEF_MAX_ROWS;
  int                usable_cols = DEF_MAX_COLS;
  // corner of an 8x8 window where most accesses land on large grids
  int                hot_row = 0;
  int                hot_col = 0;
  bit                burst_mode = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  life_grid_generation_step_top u_dut (.*);

  life_grid_checker u_life_check (.*);

  // watchdog on cycles where no word moves on any channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int usable_size(logic [SIZE_W-1:0] raw, int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return int'(raw);
  endfunction

  // window at the low edge, the high edge or somewhere between
  function automatic int place_window(int n);
    if (n <= 8) return 0;
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return n - 8;
      default: return $urandom_range(0, n - 8);
    endcase
  endfunction

  // clustered positions let patterns actually form and interact
  function automatic int pick_near(int hot, int n);
    if (n > 8 && $urandom_range(0, 3) != 0) return hot + $urandom_range(0, 7);
    return $urandom_range(0, n - 1);
  endfunction

  // one item word; start stays high across back-to-back words so it never
  // sees a drop and a rise in the same time step
  task automatic issue_word(input logic [OP_W-1:0] o, input int r, input int c, input int a);
    int gap;
    if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    op       <= o;
    row      <= POS_W'(r);
    col      <= POS_W'(c);
    alive_in <= a[0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // start must be low and every result back before the sizes move
  task automatic wait_all_answered();
    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  // valid drops for one cycle between writes
  task automatic program_size(input logic idx, input logic [SIZE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_GRID_ROWS) usable_rows = usable_size(value, DEF_MAX_ROWS);
    else usable_cols = usable_size(value, DEF_MAX_COLS);
    @(posedge clk);
  endtask

  // mostly in-range writes, reads and steps, some raw noise and unused ops
  task automatic issue_random_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      issue_word(OP_WRITE, pick_near(hot_row, usable_rows), pick_near(hot_col, usable_cols),
                 $urandom_range(0, 9) < 6);
    else if (pick < 55)
      issue_word(OP_STEP, $urandom, $urandom, $urandom);
    else if (pick < 88)
      issue_word(OP_READ, pick_near(hot_row, usable_rows), pick_near(hot_col, usable_cols),
                 $urandom);
    else if (pick < 97)
      issue_word($urandom_range(0, 1) ? OP_WRITE : OP_READ, $urandom, $urandom, $urandom);
    else
      issue_word(OP_UNUSED, $urandom, $urandom, $urandom);
  endtask

  initial begin
    logic [SIZE_W-1:0] rows_set [RANDOM_PHASES] = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd65, 7'd6,
                                                    7'd0, 7'd0};
    logic [SIZE_W-1:0] cols_set [RANDOM_PHASES] = '{7'd127, 7'd0, 7'd1, 7'd64, 7'd2, 7'd9,
                                                    7'd0, 7'd0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, full 64x64 grid from reset
    issue_word(OP_READ, 0, 0, 0);
    // l-shape in the top corner, the fourth corner cell gets three neighbours
    issue_word(OP_WRITE, 0, 0, 1);
    issue_word(OP_WRITE, 0, 1, 1);
    issue_word(OP_WRITE, 1, 0, 1);
    issue_word(OP_READ, 1, 1, 0);
    // pair at the far corner, each has only one neighbour
    issue_word(OP_WRITE, 63, 63, 1);
    issue_word(OP_WRITE, 63, 62, 1);
    issue_word(OP_READ, 63, 63, 0);
    // solid 3x3 block, the center sees all eight neighbours
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++)
        issue_word(OP_WRITE, 10 + dy, 10 + dx, 1);
    issue_word(OP_READ, 10, 10, 0);
    issue_word(OP_STEP, 0, 0, 0);
    // overcrowding, birth at the corner, loneliness at the far corner
    issue_word(OP_READ, 10, 10, 0);
    issue_word(OP_READ, 1, 1, 0);
    issue_word(OP_READ, 63, 63, 0);
    issue_word(OP_WRITE, 0, 0, 0);
    issue_word(OP_UNUSED, 63, 63, 1);

    // small grid, writes and reads past either bound are refused
    wait_all_answered();
    program_size(REG_GRID_ROWS, 7'd3);
    program_size(REG_GRID_COLS, 7'd5);
    issue_word(OP_WRITE, 3, 0, 1);
    issue_word(OP_WRITE, 0, 5, 1);
    issue_word(OP_READ, 63, 63, 0);
    issue_word(OP_WRITE, 2, 4, 1);
    issue_word(OP_READ, 2, 4, 0);

    // random phases; grids are never cleared, so cells hidden by a shrink
    // come back when a later phase grows the size again
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_all_answered();
      if (p < 6) begin
        program_size(REG_GRID_ROWS, rows_set[p]);
        program_size(REG_GRID_COLS, cols_set[p]);
      end else begin
        program_size(REG_GRID_ROWS, SIZE_W'(($urandom_range(0, 3) == 0)
                                            ? $urandom_range(0, 127) : $urandom_range(2, 12)));
        program_size(REG_GRID_COLS, SIZE_W'(($urandom_range(0, 3) == 0)
                                            ? $urandom_range(0, 127) : $urandom_range(2, 12)));
      end
      hot_row = place_window(usable_rows);
      hot_col = place_window(usable_cols);
      repeat (ITEMS_PER_PHASE) issue_random_word();
    end

    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
